[rtl/ccpb_pkg.sv]
// Shared types and constants for the constant color pixel blend unit.
package ccpb_pkg;

  // Operation codes held in the mode register
  localparam logic [2:0] MODE_FILL       = 3'd0;
  localparam logic [2:0] MODE_FILL_RGB   = 3'd1;
  localparam logic [2:0] MODE_FILL_ALPHA = 3'd2;
  localparam logic [2:0] MODE_BLEND      = 3'd3;
  localparam logic [2:0] MODE_ADDITIVE   = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_FILL_COLOR = 2'd1;
  localparam logic [1:0] REG_FILL_ALPHA = 2'd2;
  localparam logic [1:0] REG_OPACITY    = 2'd3;

  localparam int unsigned ADDR_WIDTH = 4;
  localparam int unsigned DATA_WIDTH = 32;

  localparam logic [31:0] ALPHA_MASK = 32'hff00_0000;
  localparam logic [31:0] RGB_MASK   = 32'h00ff_ffff;
  localparam logic [7:0]  CHAN_MAX   = 8'd255;
  localparam int unsigned ALPHA_LSB  = 24;

  localparam logic [7:0] OPACITY_RESET = 8'd255;

  typedef struct packed {
    logic [31:0] dest_pixel;
    logic        last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [31:0] result_pixel;
    logic        result_last;
  } pixel_out_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] fill_color;
    logic [7:0]  fill_alpha;
    logic [7:0]  opacity;
  } blend_cfg_t;

endpackage

[rtl/constant_color_pixel_blend_unit.sv]
// Top level of the constant color pixel blend unit: registers, pipeline, handshakes.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one destination ARGB
//   pixel and its end-of-span flag per transaction. rsp channel
//   (rsp_valid/rsp_ready/rsp_data) returns exactly one processed pixel per
//   request transaction, in order, with the flag copied through.
//   The APB-style port sets mode, fill_color, fill_alpha and opacity at byte
//   addresses 0, 4, 8 and 12; write it only while no pixel is in flight.
//   Path: a request passes through the input register, then the blend logic
//   feeding the result register, before rsp_valid rises; a stall on the rsp
//   channel can hold it there. Throughput: one pixel per cycle while rsp_ready
//   is high; the blend datapath is a single stage of 8x8 and 8x9-bit multipliers
//   and byte adds, so every cycle without a stall can take a new pixel.
//   Stall: when rsp_ready is low the result register holds, the input
//   register fills behind it, and req_ready drops once both are full.
//   Reset (rst, synchronous): clears both pipeline valid flags and returns
//   the registers to mode fill, color 0, fill alpha 0, opacity 255.
module constant_color_pixel_blend_unit
  import ccpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  pixel_in_t             req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output pixel_out_t            rsp_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  blend_cfg_t cfg;
  pixel_in_t  s1_data;
  logic       s1_valid;
  logic       s1_advance;
  pixel_out_t core_res;

  ccpb_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the input stage whenever the result register is empty or draining
  assign s1_advance = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready  = !s1_valid || s1_advance;

  // Input register: capture a new transaction, otherwise hold
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_data <= req_data;
    end
  end

  ccpb_blend_core u_blend_core (
    .cfg (cfg),
    .pix (s1_data),
    .res (core_res)
  );

  // Result register: load on advance, drop valid once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp_data <= core_res;
    end
  end

`ifndef SYNTH
  // Both stages come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !rsp_valid))
    else $error("pipeline not empty after reset");

  // A pixel leaving the input stage shows up in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> (rsp_valid && rsp_data == $past(core_res)))
    else $error("advanced pixel missing from result register");

  // A stalled input stage keeps its pixel
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_data)))
    else $error("input stage lost a stalled pixel");

  // An empty input stage always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> req_ready)
    else $error("request refused with empty input stage");
`endif

endmodule

[rtl/ccpb_cfg_regs.sv]
// Configuration register file behind the APB-style port.
module ccpb_cfg_regs
  import ccpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output blend_cfg_t            cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_FILL;
      cfg.fill_color <= '0;
      cfg.fill_alpha <= '0;
      cfg.opacity    <= OPACITY_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_MODE:       cfg.mode       <= pwdata[2:0];
        REG_FILL_COLOR: cfg.fill_color <= pwdata;
        REG_FILL_ALPHA: cfg.fill_alpha <= pwdata[7:0];
        REG_OPACITY:    cfg.opacity    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_MODE:       prdata = {29'd0, cfg.mode};
      REG_FILL_COLOR: prdata = cfg.fill_color;
      REG_FILL_ALPHA: prdata = {24'd0, cfg.fill_alpha};
      REG_OPACITY:    prdata = {24'd0, cfg.opacity};
      default:        prdata = '0;
    endcase
  end

endmodule

[rtl/ccpb_blend_core.sv]
// Per-pixel fill, blend and additive datapath, one pixel per cycle.
module ccpb_blend_core
  import ccpb_pkg::*;
(
  input  blend_cfg_t cfg,
  input  pixel_in_t  pix,
  output pixel_out_t res
);

  logic [7:0]  o_inv;
  logic [8:0]  op;
  logic [7:0]  d_ch  [4];
  logic [7:0]  c_ch  [4];
  logic [16:0] mix   [3];
  logic [16:0] d_scl [4];
  logic [16:0] c_scl [3];
  logic [8:0]  add   [4];
  logic [8:0]  sum   [4];
  logic [31:0] blend_pix;
  logic [31:0] add_pix;

  assign o_inv = CHAN_MAX - cfg.opacity;
  assign op    = {1'b0, cfg.opacity} + {8'd0, cfg.opacity[7]};

  always_comb begin
    blend_pix = pix.dest_pixel & ALPHA_MASK;
    add_pix   = '0;
    for (int k = 0; k < 4; k++) begin
      d_ch[k]  = pix.dest_pixel[8*k +: 8];
      c_ch[k]  = cfg.fill_color[8*k +: 8];
      d_scl[k] = 17'(d_ch[k]) * 17'(op);
    end
    for (int k = 0; k < 3; k++) begin
      mix[k]   = 17'(d_ch[k]) * 17'(o_inv) + 17'(c_ch[k]) * 17'(cfg.opacity);
      c_scl[k] = 17'(c_ch[k]) * 17'(op);
      add[k]   = c_scl[k][16:8];
      blend_pix[8*k +: 8] = mix[k][15:8];
    end
    add[3] = {1'b0, op[7:0]};
    for (int k = 0; k < 4; k++) begin
      // d*op>>8 never exceeds d, so the difference stays non-negative
      sum[k] = ({1'b0, d_ch[k]} - d_scl[k][16:8]) + add[k];
      add_pix[8*k +: 8] = sum[k][8] ? CHAN_MAX : sum[k][7:0];
    end
  end

  always_comb begin
    res.result_last = pix.last_pixel;
    unique case (cfg.mode)
      MODE_FILL:       res.result_pixel = cfg.fill_color;
      MODE_FILL_RGB:   res.result_pixel = (pix.dest_pixel & ALPHA_MASK)
                                          | (cfg.fill_color & RGB_MASK);
      MODE_FILL_ALPHA: res.result_pixel = (pix.dest_pixel & RGB_MASK)
                                          | {cfg.fill_alpha, 24'd0};
      MODE_BLEND:      res.result_pixel = blend_pix;
      MODE_ADDITIVE:   res.result_pixel = add_pix;
      default:         res.result_pixel = pix.dest_pixel;
    endcase
  end

endmodule
